>>> rtl/bcdc_pkg.sv
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types, constants and the segment decoder for the BCD up/down counter
// with display scan.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    localparam int unsigned LimitW     = 16;
    localparam int unsigned ScanW      = 3;
    localparam int unsigned DigitW     = 4;
    localparam int unsigned NumDigits  = 4;
    localparam int unsigned SegW       = 7;

    localparam logic [LimitW-1:0] LIMIT_RESET = 16'd300;
    localparam logic [ScanW-1:0]  SCAN_LAST   = 3'd4;
    localparam logic [DigitW-1:0] DIGIT_MAX   = 4'd9;

    typedef logic [NumDigits-1:0][DigitW-1:0] t_digits;

    // Architectural state carried from one pass to the next
    typedef struct packed {
        logic [LimitW-1:0] prescale_count;
        logic [ScanW-1:0]  scan_index;
        t_digits           digits;
        logic [DigitW-1:0] held_digit;
    } t_cnt_state;

    // One result beat
    typedef struct packed {
        logic [ScanW-1:0]  digit_select;
        logic [SegW-1:0]   segments;
        logic [DigitW-1:0] ones_digit;
        logic [DigitW-1:0] tens_digit;
        logic [DigitW-1:0] hundreds_digit;
        logic [DigitW-1:0] thousands_digit;
    } t_result;

    // Seven-segment pattern, bit0 = segment a; non-BCD codes blank
    function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] d);
        logic [SegW-1:0] seg;
        unique case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

>>> rtl/bcdc_ifs.sv
// ----------------------------------------------------------------------------
// bcdc channel interfaces
// Valid/ready channels for the pass-tick input and the display result.
// ----------------------------------------------------------------------------
interface bcdc_in_if;
    logic valid;
    logic ready;
    logic count_down;

    modport source (output valid, output count_down, input ready);
    modport sink   (input valid, input count_down, output ready);
endinterface

interface bcdc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] digit_select;
    logic [6:0] segments;
    logic [3:0] ones_digit;
    logic [3:0] tens_digit;
    logic [3:0] hundreds_digit;
    logic [3:0] thousands_digit;

    modport source (output valid, output digit_select, output segments,
                    output ones_digit, output tens_digit, output hundreds_digit,
                    output thousands_digit, input ready);
    modport sink   (input valid, input digit_select, input segments,
                    input ones_digit, input tens_digit, input hundreds_digit,
                    input thousands_digit, output ready);
endinterface

>>> rtl/bcdc_step.sv
// ----------------------------------------------------------------------------
// bcdc_step
// One main-loop pass: two prescaler advances, scan step, BCD count step,
// held-digit latch and segment lookup. Purely combinational.
// ----------------------------------------------------------------------------
module bcdc_step (
    input  logic                        i_count_down,
    input  logic [bcdc_pkg::LimitW-1:0] i_limit,
    input  bcdc_pkg::t_cnt_state        i_state,
    output bcdc_pkg::t_cnt_state        o_state,
    output bcdc_pkg::t_result           o_result
);
    import bcdc_pkg::*;

    logic              hit1;
    logic              hit2;
    logic [LimitW-1:0] cnt1;
    logic [ScanW-1:0]  scan_nxt;
    logic [ScanW-1:0]  scan_m1;
    t_digits           digits_nxt;
    logic [DigitW-1:0] held_nxt;

    // two advances; the period flag is consumed within the same pass
    always_comb begin
        hit1 = (i_state.prescale_count == i_limit);
        cnt1 = hit1 ? '0 : i_state.prescale_count + LimitW'(1);
        hit2 = (cnt1 == i_limit);
        o_state.prescale_count = hit2 ? '0 : cnt1 + LimitW'(1);
    end

    assign scan_nxt = (i_state.scan_index >= SCAN_LAST) ? '0
                                                        : i_state.scan_index + ScanW'(1);
    assign scan_m1  = scan_nxt - ScanW'(1);

    // ripple borrow/carry through the four digits
    always_comb begin
        logic carry;
        carry      = hit1 | hit2;
        digits_nxt = i_state.digits;
        for (int k = 0; k < NumDigits; k++) begin
            if (carry) begin
                if (i_count_down) begin
                    if (i_state.digits[k] == '0) begin
                        digits_nxt[k] = DIGIT_MAX;
                    end else begin
                        digits_nxt[k] = i_state.digits[k] - DigitW'(1);
                        carry = 1'b0;
                    end
                end else begin
                    if (i_state.digits[k] >= DIGIT_MAX) begin
                        digits_nxt[k] = '0;
                    end else begin
                        digits_nxt[k] = i_state.digits[k] + DigitW'(1);
                        carry = 1'b0;
                    end
                end
            end
        end
    end

    // scan index zero keeps the last held digit
    assign held_nxt = (scan_nxt == '0) ? i_state.held_digit : digits_nxt[scan_m1[1:0]];

    assign o_state.scan_index = scan_nxt;
    assign o_state.digits     = digits_nxt;
    assign o_state.held_digit = held_nxt;

    assign o_result.digit_select    = scan_nxt;
    assign o_result.segments        = seg_decode(held_nxt);
    assign o_result.ones_digit      = digits_nxt[0];
    assign o_result.tens_digit      = digits_nxt[1];
    assign o_result.hundreds_digit  = digits_nxt[2];
    assign o_result.thousands_digit = digits_nxt[3];

endmodule

>>> rtl/bcd_updown_counter_display_scan.sv
// ----------------------------------------------------------------------------
// bcd_updown_counter_display_scan
// Four-digit BCD up/down counter with multiplexed seven-segment scan output.
// ----------------------------------------------------------------------------
//  channel   dir   handshake         beat contents
//  i_in      in    valid/ready       count_down (one main-loop pass)
//  o_out     out   valid/ready       digit_select, segments, four BCD digits
//  cfg       in    i_cfg_we          i_cfg_wdata -> prescale limit
//
//  One beat per clock sustained while o_out accepts; each taken beat's
//  result is registered. State updates at the input beat, the result
//  goes to an output register backed by a one-entry skid, so input stays
//  ready while a single result waits. Input ready drops only when both are
//  full. Synchronous active-low reset clears state, limit returns to 300.
// ----------------------------------------------------------------------------
module bcd_updown_counter_display_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bcdc_pkg::LimitW-1:0] i_cfg_wdata,
    bcdc_in_if.sink                     i_in,
    bcdc_out_if.source                  o_out
);
    import bcdc_pkg::*;

    logic [LimitW-1:0] r_limit;
    t_cnt_state        r_state;
    t_cnt_state        n_state;
    t_result           n_result;
    t_result           r_out;
    t_result           r_skid;
    logic              r_out_valid;
    logic              r_skid_valid;
    logic              in_fire;
    logic              out_free;

    bcdc_step u_step (
        .i_count_down (i_in.count_down),
        .i_limit      (r_limit),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || in_fire;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_fire && !out_free) begin
            r_skid <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.digit_select    = r_out.digit_select;
    assign o_out.segments        = r_out.segments;
    assign o_out.ones_digit      = r_out.ones_digit;
    assign o_out.tens_digit      = r_out.tens_digit;
    assign o_out.hundreds_digit  = r_out.hundreds_digit;
    assign o_out.thousands_digit = r_out.thousands_digit;

    // skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output beat");

    // every taken input beat leaves a result pending next cycle
    a_in_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("input beat lost");

    // count stays valid BCD
    a_bcd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.digits[0] <= DIGIT_MAX && r_state.digits[1] <= DIGIT_MAX &&
        r_state.digits[2] <= DIGIT_MAX && r_state.digits[3] <= DIGIT_MAX)
        else $error("BCD digit out of range");

    // scan index wraps after four
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.scan_index <= SCAN_LAST)
        else $error("scan index out of range");

endmodule

>>> dv/tb_bcd_updown_counter_display_scan.sv
// ----------------------------------------------------------------------------
// tb_bcd_updown_counter_display_scan
// Self-checking bench for the BCD up/down counter with display scan. A short
// scripted sequence covers reset, both digit wraps, the idle scan slot and the
// limit extremes. Random phases under changing prescale limits follow, then
// a limit dropped under the running prescaler. Every display beat is checked
// field by field against a hand-written beat or an in-bench model of the counter.
// ----------------------------------------------------------------------------
module tb_bcd_updown_counter_display_scan;
    timeunit 1ns;
    timeprecision 1ps;

    import bcdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned RANDOM_PASSES = 500;
    localparam int unsigned FINAL_PASSES  = 150;
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned MAX_REPORTS   = 100;

    localparam logic COUNT_UP   = 1'b0;
    localparam logic COUNT_DOWN = 1'b1;

    typedef enum logic {ROW_PASS, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [LimitW-1:0] arg;     // direction for a pass, value for a limit
        logic              typed;   // use the hand-written beat below
        t_result           want;
    } t_script_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [LimitW-1:0]   i_cfg_wdata;

    bcdc_in_if  in_ch ();
    bcdc_out_if out_ch ();

    bcd_updown_counter_display_scan uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Scripted opening: limit 2 after three advances gives a count on most passes
    t_script_row script [16] = '{
        '{ROW_PASS,  16'(COUNT_UP),   1'b1, '{3'd1, 7'h3F, 4'd0, 4'd0, 4'd0, 4'd0}},
        '{ROW_LIMIT, 16'd2,           1'b0, '0},
        '{ROW_PASS,  16'(COUNT_DOWN), 1'b1, '{3'd2, 7'h6F, 4'd9, 4'd9, 4'd9, 4'd9}},
        '{ROW_PASS,  16'(COUNT_UP),   1'b1, '{3'd3, 7'h3F, 4'd0, 4'd0, 4'd0, 4'd0}},
        '{ROW_PASS,  16'(COUNT_UP),   1'b1, '{3'd4, 7'h3F, 4'd0, 4'd0, 4'd0, 4'd0}},
        '{ROW_PASS,  16'(COUNT_UP),   1'b1, '{3'd0, 7'h3F, 4'd1, 4'd0, 4'd0, 4'd0}},
        '{ROW_PASS,  16'(COUNT_UP),   1'b1, '{3'd1, 7'h5B, 4'd2, 4'd0, 4'd0, 4'd0}},
        '{ROW_LIMIT, 16'd0,           1'b0, '0},
        '{ROW_PASS,  16'(COUNT_DOWN), 1'b0, '0},
        '{ROW_PASS,  16'(COUNT_DOWN), 1'b0, '0},
        '{ROW_PASS,  16'(COUNT_DOWN), 1'b0, '0},
        '{ROW_PASS,  16'(COUNT_UP),   1'b0, '0},
        '{ROW_LIMIT, 16'hFFFF,        1'b0, '0},
        '{ROW_PASS,  16'(COUNT_DOWN), 1'b0, '0},
        '{ROW_PASS,  16'(COUNT_UP),   1'b0, '0},
        '{ROW_PASS,  16'(COUNT_DOWN), 1'b0, '0}
    };

    logic [SegW-1:0] seg_of [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
        7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Counter model state
    logic [LimitW-1:0] lim_q;
    logic [LimitW-1:0] presc_q;
    logic              tick_q;
    logic [ScanW-1:0]  scan_q;
    logic [DigitW-1:0] digit_q [NumDigits];
    logic [DigitW-1:0] held_q;

    t_result     pending_display [$];
    bit          quiet;
    bit          hold_req;
    int unsigned gap_pct = 25;
    int unsigned n_passes, n_counts, n_limit_writes, n_shown, n_errors;
    int unsigned n_cycles, max_in_wait;

    function automatic t_result advance_display(input logic down);
        t_result r;
        int      k;
        repeat (2) begin
            if (presc_q == lim_q) begin
                tick_q  = 1'b1;
                presc_q = '0;
            end else begin
                presc_q = presc_q + 1'b1;
            end
        end
        scan_q = (scan_q == SCAN_LAST) ? '0 : scan_q + 1'b1;
        if (tick_q) begin
            tick_q = 1'b0;
            n_counts++;
            for (k = 0; k < NumDigits; k++) begin
                if (down) begin
                    if (digit_q[k] == '0) begin
                        digit_q[k] = DIGIT_MAX;
                    end else begin
                        digit_q[k] = digit_q[k] - 1'b1;
                        break;
                    end
                end else begin
                    if (digit_q[k] >= DIGIT_MAX) begin
                        digit_q[k] = '0;
                    end else begin
                        digit_q[k] = digit_q[k] + 1'b1;
                        break;
                    end
                end
            end
        end
        // slot zero keeps the digit latched last
        if (scan_q != '0) begin
            held_q = digit_q[2'(scan_q - 1'b1)];
        end
        r.digit_select    = scan_q;
        r.segments        = seg_of[held_q];
        r.ones_digit      = digit_q[0];
        r.tens_digit      = digit_q[1];
        r.hundreds_digit  = digit_q[2];
        r.thousands_digit = digit_q[3];
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_pass(input logic down, input logic typed, input t_result want);
        t_result     got;
        int unsigned waited;
        if (!quiet && $urandom_range(99, 0) < gap_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.count_down <= down;
        waited = 0;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            waited++;
            @(posedge i_clk);
        end
        if (waited > max_in_wait) begin
            max_in_wait = waited;
        end
        got = advance_display(down);
        pending_display.push_back(typed ? want : got);
        n_passes++;
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LimitW-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_display.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lim_q = value;
        n_limit_writes++;
    endtask

    task automatic run_phase(input int unsigned passes);
        int unsigned down_pct;
        case ($urandom_range(2, 0))
            0:       down_pct = 10;
            1:       down_pct = 50;
            default: down_pct = 90;
        endcase
        repeat (passes) send_pass($urandom_range(99, 0) < down_pct, 1'b0, '0);
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("%0t ns %s: expected %0d, actual %0d", $time, label, want, got);
            end
        end
    endtask

    // Result side: ready pattern, with one long hold-off to back up the block
    initial begin
        int unsigned hold_left;
        int unsigned idle_left;
        bit          hold_done;
        out_ch.ready = 1'b0;
        hold_left    = 0;
        idle_left    = 0;
        hold_done    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && hold_req) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_left != 0) begin
                idle_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(99, 0) < gap_pct) begin
                idle_left = $urandom_range(11, 0);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_display
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_display.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("%0t ns display beat with nothing expected: select %0d",
                             $time, out_ch.digit_select);
                end
            end else begin
                want = pending_display.pop_front();
                check_field("digit_select", 16'(want.digit_select),
                            16'(out_ch.digit_select));
                check_field("segments", 16'(want.segments), 16'(out_ch.segments));
                check_field("ones_digit", 16'(want.ones_digit), 16'(out_ch.ones_digit));
                check_field("tens_digit", 16'(want.tens_digit), 16'(out_ch.tens_digit));
                check_field("hundreds_digit", 16'(want.hundreds_digit),
                            16'(out_ch.hundreds_digit));
                check_field("thousands_digit", 16'(want.thousands_digit),
                            16'(out_ch.thousands_digit));
                n_shown++;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d beats outstanding",
                     pending_display.size());
            $display("bcd_updown_counter_display_scan: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned       sent;
        int unsigned       hits;
        logic [LimitW-1:0] pick;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.count_down = COUNT_UP;
        lim_q            = LIMIT_RESET;
        presc_q          = '0;
        tick_q           = 1'b0;
        scan_q           = '0;
        held_q           = '0;
        foreach (digit_q[k]) digit_q[k] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[r]) begin
            if (script[r].kind == ROW_LIMIT) begin
                write_limit(script[r].arg);
            end else begin
                send_pass(script[r].arg[0], script[r].typed, script[r].want);
            end
        end

        sent = 0;
        while (sent < RANDOM_PASSES) begin
            case ($urandom_range(9, 0))
                0:          pick = '0;
                1:          pick = 16'd1;
                2, 3, 4, 5: pick = LimitW'($urandom_range(12, 2));
                6:          pick = '1;
                7:          pick = LimitW'($urandom_range(400, 13));
                8:          pick = LIMIT_RESET;
                default:    pick = LimitW'($urandom());
            endcase
            write_limit(pick);
            hits = $urandom_range(80, 20);
            // receiver backs off for a long stretch while this phase keeps sending
            if (sent == 0) begin
                hold_req = 1'b1;
            end
            run_phase(hits);
            sent += hits;
        end

        // Drop the limit under the running prescaler: it keeps counting up past it
        gap_pct = 3;
        write_limit('1);
        while (presc_q < 2) send_pass(1'($urandom_range(1, 0)), 1'b0, '0);
        write_limit(presc_q - 1'b1);
        run_phase(20);

        gap_pct = 25;
        quiet   = 1'b1;
        write_limit(16'd1);
        run_phase(FINAL_PASSES);
        in_ch.valid <= 1'b0;

        while (pending_display.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d counter passes, %0d BCD count steps, %0d prescale limit writes",
                 n_passes, n_counts, n_limit_writes);
        $display("Limits 0, 1, 65535 and one under the prescaler seen; longest input stall %0d",
                 max_in_wait);
        if (n_errors == 0) begin
            $display("bcd_updown_counter_display_scan: match");
        end else begin
            $display("bcd_updown_counter_display_scan: mismatch");
        end
        $finish;
    end

endmodule
